[src/pat_pkg.sv]
// Shared types, codes and defaults for the positional array table.
package pat_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int OP_W     = 2;
  localparam int POS_W    = 5;
  localparam int IO_VAL_W = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVER     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic [POS_W-1:0]           found_position;
    logic signed [IO_VAL_W-1:0] read_value;
    logic [COUNT_W-1:0]         entry_count;
  } res_t;

endpackage

[src/pat_mem.sv]
// Entry store: one write port, one read port with registered read data.
module pat_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/pat_ctrl.sv]
// Sequencer: checks positions, shifts entries through the memory, searches and reads.
module pat_ctrl #(
  parameter int CAPACITY    = pat_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = pat_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [pat_pkg::OP_W-1:0]             in_operation,
  input  logic [pat_pkg::POS_W-1:0]            in_position,
  input  logic signed [pat_pkg::IO_VAL_W-1:0]  in_value,
  output logic                                 mem_we,
  output logic [$clog2(CAPACITY)-1:0]          mem_waddr,
  output logic [VALUE_WIDTH-1:0]               mem_wdata,
  output logic                                 mem_re,
  output logic [$clog2(CAPACITY)-1:0]          mem_raddr,
  input  logic [VALUE_WIDTH-1:0]               mem_rdata,
  output logic                                 res_valid,
  output pat_pkg::res_t                        res,
  input  logic                                 res_take
);
  import pat_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SHIFT  = 3'd1;
  localparam logic [2:0] S_FIN    = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]             state_r, state_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [OP_W-1:0]        op_r, op_nxt;
  logic [AW-1:0]          pos_r, pos_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [AW-1:0]          rd_addr_r, rd_addr_nxt;
  logic                   last_r, last_nxt;
  res_t                   res_r, res_nxt;

  logic [CMP_W-1:0]       pos_c, cnt_c;
  logic [AW-1:0]          pos_m1, cnt_m1, step_addr, end_addr;
  logic signed [63:0]     in_v64, rd_v64;

  always_comb begin
    pos_c     = CMP_W'(in_position);
    cnt_c     = CMP_W'(cnt_r);
    pos_m1    = AW'(pos_c - CMP_W'(1));
    cnt_m1    = AW'(cnt_c - CMP_W'(1));
    in_v64    = 64'(in_value);
    rd_v64    = 64'(signed'(mem_rdata));
    step_addr = (op_r == OP_INSERT) ? (rd_addr_r - AW'(1)) : (rd_addr_r + AW'(1));
    end_addr  = (op_r == OP_INSERT) ? pos_r : cnt_m1;

    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    op_nxt      = op_r;
    pos_nxt     = pos_r;
    val_nxt     = val_r;
    rd_addr_nxt = rd_addr_r;
    last_nxt    = last_r;
    res_nxt     = res_r;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    case (state_r)
      S_IDLE: begin
        res_nxt.status         = ST_OK;
        res_nxt.found_position = '0;
        res_nxt.read_value     = '0;
        res_nxt.entry_count    = COUNT_W'(cnt_r);
        if (in_valid) begin
          op_nxt  = in_operation;
          pos_nxt = pos_m1;
          val_nxt = in_v64[VALUE_WIDTH-1:0];
          state_nxt = S_DONE;
          case (in_operation)
            OP_INSERT: begin
              if (pos_c == '0) begin
                res_nxt.status = ST_UNDER;
              end else if (pos_c > cnt_c + CMP_W'(1)) begin
                res_nxt.status = ST_OVER;
              end else if (cnt_c == CMP_W'(CAPACITY)) begin
                res_nxt.status = ST_FULL;
              end else if (pos_c == cnt_c + CMP_W'(1)) begin
                state_nxt = S_FIN;
              end else begin
                // Shift from the top entry down to the insert position.
                mem_re      = 1'b1;
                mem_raddr   = cnt_m1;
                rd_addr_nxt = cnt_m1;
                last_nxt    = (cnt_m1 == pos_m1);
                state_nxt   = S_SHIFT;
              end
            end
            OP_DELETE: begin
              if (pos_c == '0) begin
                res_nxt.status = ST_UNDER;
              end else if (pos_c > cnt_c) begin
                res_nxt.status = ST_OVER;
              end else if (pos_c == cnt_c) begin
                state_nxt = S_FIN;
              end else begin
                // Pull entries above the hole down by one.
                mem_re      = 1'b1;
                mem_raddr   = AW'(pos_c);
                rd_addr_nxt = AW'(pos_c);
                last_nxt    = (AW'(pos_c) == cnt_m1);
                state_nxt   = S_SHIFT;
              end
            end
            OP_SEARCH: begin
              if (cnt_r == '0) begin
                res_nxt.status = ST_NOTFOUND;
              end else begin
                mem_re      = 1'b1;
                mem_raddr   = '0;
                rd_addr_nxt = '0;
                last_nxt    = (cnt_m1 == '0);
                state_nxt   = S_SEARCH;
              end
            end
            OP_READ: begin
              if (pos_c == '0) begin
                res_nxt.status = ST_UNDER;
              end else if (pos_c > cnt_c) begin
                res_nxt.status = ST_OVER;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = pos_m1;
                state_nxt = S_RDWAIT;
              end
            end
            default: begin
              res_nxt.status = ST_OK;
            end
          endcase
        end
      end
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = (op_r == OP_INSERT) ? (rd_addr_r + AW'(1)) : (rd_addr_r - AW'(1));
        mem_wdata = mem_rdata;
        if (last_r) begin
          state_nxt = S_FIN;
        end else begin
          mem_re      = 1'b1;
          mem_raddr   = step_addr;
          rd_addr_nxt = step_addr;
          last_nxt    = (step_addr == end_addr);
        end
      end
      S_FIN: begin
        if (op_r == OP_INSERT) begin
          mem_we    = 1'b1;
          mem_waddr = pos_r;
          mem_wdata = val_r;
          cnt_nxt   = cnt_r + CW'(1);
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
        end
        res_nxt.entry_count = COUNT_W'(cnt_nxt);
        state_nxt = S_DONE;
      end
      S_SEARCH: begin
        if (mem_rdata == val_r) begin
          res_nxt.found_position = POS_W'({1'b0, rd_addr_r} + (AW + 1)'(1));
          state_nxt = S_DONE;
        end else if (last_r) begin
          res_nxt.status = ST_NOTFOUND;
          state_nxt = S_DONE;
        end else begin
          mem_re      = 1'b1;
          mem_raddr   = rd_addr_r + AW'(1);
          rd_addr_nxt = rd_addr_r + AW'(1);
          last_nxt    = ((rd_addr_r + AW'(1)) == cnt_m1);
        end
      end
      S_RDWAIT: begin
        res_nxt.read_value = rd_v64[IO_VAL_W-1:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    rd_addr_r <= rd_addr_nxt;
    last_r    <= last_nxt;
    res_r     <= res_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write hit the same entry");

  a_cnt_only_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_FIN) |=> $stable(cnt_r))
    else $error("entry count changed outside finish");

  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_take) |=> (state_r == S_IDLE))
    else $error("result handed off but sequencer not idle");

endmodule

[src/positional_array_table.sv]
// Top level of the positional array table: sequencer, entry store and result register.
// Position errors, full inserts and empty searches go straight to the result; a read waits
// for the registered read data; insert shifts entries from the top down to the position,
// delete pulls the entries above it down, and search scans from the first entry until a
// match or the last entry. Items are taken one at a time through the single read and
// single write port of the entry store. Reset clears the count, the sequencer state and
// out_valid; the store keeps its contents and needs no clearing pass.
module positional_array_table #(
  parameter int CAPACITY    = pat_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = pat_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pat_pkg::OP_W-1:0]            in_operation,
  input  logic [pat_pkg::POS_W-1:0]           in_position,
  input  logic signed [pat_pkg::IO_VAL_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pat_pkg::STATUS_W-1:0]        out_status,
  output logic [pat_pkg::POS_W-1:0]           out_found_position,
  output logic signed [pat_pkg::IO_VAL_W-1:0] out_read_value,
  output logic [pat_pkg::COUNT_W-1:0]         out_entry_count
);
  import pat_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  // Store port wires between the sequencer and the memory.
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  logic res_valid;
  res_t res;
  logic res_take;

  logic out_valid_r, out_valid_nxt;
  res_t out_r;

  pat_ctrl #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_position  (in_position),
    .in_value     (in_value),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .res_valid    (res_valid),
    .res          (res),
    .res_take     (res_take)
  );

  pat_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The output register frees when empty or when its item leaves this cycle.
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result payload only when a new item moves in; hold it while stalled.
  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_found_position = out_r.found_position;
  assign out_read_value     = out_r.read_value;
  assign out_entry_count    = out_r.entry_count;

  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_take) |=> res_valid)
    else $error("sequencer dropped a result waiting for the output register");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_take) |=> out_valid_r)
    else $error("result taken but output register not valid");

  a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.status <= ST_FULL))
    else $error("result status out of range");

endmodule
